FILE: rtl/core/ucd_pkg.sv
// ucd_pkg: types, constants and lead-byte helpers for the utf-8 codepoint decoder
// used by ucd_front, ucd_queue, ucd_back and utf8_codepoint_decoder_unit
// no dependencies
package ucd_pkg;

    localparam int CpW     = 21;
    localparam int UsedW   = 3;
    localparam int ByteW   = 8;
    localparam int PendN   = 3;
    localparam int CntW    = 2;
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int QLvlW   = $clog2(QDepth + 1);

    localparam logic [ByteW-1:0] Lead4Min = 8'hF0;
    localparam logic [ByteW-1:0] Lead3Min = 8'hE0;
    localparam logic [ByteW-1:0] Lead2Min = 8'hC0;
    localparam logic [ByteW-1:0] Mask4    = 8'h07;
    localparam logic [ByteW-1:0] Mask3    = 8'h0F;
    localparam logic [ByteW-1:0] Mask2    = 8'h1F;
    localparam logic [1:0]       ContTag  = 2'b10;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             end_of_text;
    } ucd_in_t;

    typedef struct packed {
        logic [CpW-1:0]   codepoint;
        logic [UsedW-1:0] bytes_used;
        logic             run_end;
        logic             text_end;
    } ucd_out_t;

    // one accepted byte's worth of results: raw flushed bytes, then an optional final one
    typedef struct packed {
        logic [CntW-1:0]               nflush;
        logic [PendN-1:0][ByteW-1:0]   flush_bytes;
        logic                          has_final;
        logic [CpW-1:0]                final_cp;
        logic [UsedW-1:0]              final_used;
        logic                          last;
    } ucd_job_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ucd_qctl_t;

    function automatic logic [CntW-1:0] lead_need(input logic [ByteW-1:0] b);
        logic [CntW-1:0] n;
        begin
            if (b >= Lead4Min)
                n = 2'd3;
            else if (b >= Lead3Min)
                n = 2'd2;
            else if (b >= Lead2Min)
                n = 2'd1;
            else
                n = 2'd0;
            return n;
        end
    endfunction

    function automatic logic [CpW-1:0] lead_bits(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] m;
        begin
            if (b >= Lead4Min)
                m = b & Mask4;
            else if (b >= Lead3Min)
                m = b & Mask3;
            else if (b >= Lead2Min)
                m = b & Mask2;
            else
                m = b;
            return {{(CpW-ByteW){1'b0}}, m};
        end
    endfunction

endpackage

FILE: rtl/core/ucd_front.sv
// ucd_front: takes bytes, tracks the open sequence and builds at most one result job per byte
// depends on ucd_pkg
module ucd_front
    import ucd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  ucd_in_t  item,
    output logic     job_valid,
    output ucd_job_t job
);

    logic [PendN-1:0][ByteW-1:0] pend_reg, pend_next;
    logic [CntW-1:0]             count_reg, count_next;
    logic [CntW-1:0]             need_reg, need_next;
    logic [CpW-1:0]              partial_reg, partial_next;

    logic [ByteW-1:0] b;
    logic             last;
    logic             is_cont;
    logic             fresh;
    logic [CntW-1:0]  b_need;
    logic [CpW-1:0]   v_ext;

    assign b       = item.data_byte;
    assign last    = item.end_of_text;
    assign is_cont = (b[7:6] == ContTag);
    assign fresh   = (count_reg == '0) || (need_reg == '0);
    assign b_need  = lead_need(b);
    assign v_ext   = {partial_reg[CpW-7:0], b[5:0]};

    always_comb
    begin
        pend_next      = pend_reg;
        count_next     = count_reg;
        need_next      = need_reg;
        partial_next   = partial_reg;
        job            = '0;
        job.flush_bytes = pend_reg;
        job.last       = last;

        if (!fresh && is_cont)
        begin
            if (need_reg == 2'd1)
            begin
                job.has_final  = 1'b1;
                job.final_cp   = v_ext;
                job.final_used = {1'b0, count_reg} + 3'd1;
                count_next     = '0;
                need_next      = '0;
                partial_next   = '0;
            end
            else if (last || count_reg == 2'd3)
            begin
                // early end: flush buffered bytes, the continuation byte goes out raw
                job.nflush     = count_reg;
                job.has_final  = 1'b1;
                job.final_cp   = {{(CpW-ByteW){1'b0}}, b};
                job.final_used = 3'd1;
                count_next     = '0;
                need_next      = '0;
                partial_next   = '0;
            end
            else
            begin
                pend_next[count_reg] = b;
                count_next           = count_reg + 2'd1;
                need_next            = need_reg - 2'd1;
                partial_next         = v_ext;
            end
        end
        else
        begin
            // fresh decode, after flushing a broken sequence if one is open
            job.nflush = fresh ? 2'd0 : count_reg;
            if (b_need == '0 || last)
            begin
                job.has_final  = 1'b1;
                job.final_cp   = {{(CpW-ByteW){1'b0}}, b};
                job.final_used = 3'd1;
                count_next     = '0;
                need_next      = '0;
                partial_next   = '0;
            end
            else
            begin
                pend_next[0] = b;
                count_next   = 2'd1;
                need_next    = b_need;
                partial_next = lead_bits(b);
            end
        end
    end

    assign job_valid = accept && ((job.nflush != '0) || job.has_final);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            need_reg    <= '0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            count_reg   <= count_next;
            need_reg    <= need_next;
            partial_reg <= partial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= pend_next;
    end

endmodule

FILE: rtl/core/ucd_queue.sv
// ucd_queue: small job queue between the front and back parts
// depends on ucd_pkg
module ucd_queue
    import ucd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ucd_job_t  wr_job,
    output ucd_job_t  rd_job,
    input  ucd_qctl_t ctl_in,
    output logic      full,
    output logic      empty
);

    ucd_job_t          mem [QDepth];
    logic [QPtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QLvlW-1:0]  level_reg, level_next;

    assign full   = (level_reg == QLvlW'(QDepth));
    assign empty  = (level_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (ctl_in.push && !ctl_in.pop)
            level_next = level_reg + QLvlW'(1);
        else if (!ctl_in.push && ctl_in.pop)
            level_next = level_reg - QLvlW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (ctl_in.push)
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            if (ctl_in.pop)
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.push)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

FILE: rtl/core/ucd_back.sv
// ucd_back: expands queued jobs into codepoint items, one a cycle while cp_ready allows, into the output register
// depends on ucd_pkg
module ucd_back
    import ucd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ucd_job_t job,
    input  logic     empty,
    output logic     pop,
    output logic     cp_valid,
    input  logic     cp_ready,
    output ucd_out_t cp_item
);

    logic [CntW-1:0]  idx_reg, idx_next;
    logic             valid_reg;
    ucd_out_t         item_reg, item_next;
    logic [UsedW-1:0] total;
    logic             take;
    logic             last_res;
    logic [ByteW-1:0] flush_byte;

    assign total    = {1'b0, job.nflush} + {2'b0, job.has_final};
    assign take     = !empty && (!valid_reg || cp_ready);
    assign last_res = (({1'b0, idx_reg} + 3'd1) == total);
    assign pop      = take && last_res;

    always_comb
    begin
        case (idx_reg)
            2'd0:    flush_byte = job.flush_bytes[0];
            2'd1:    flush_byte = job.flush_bytes[1];
            2'd2:    flush_byte = job.flush_bytes[2];
            default: flush_byte = '0;
        endcase
    end

    always_comb
    begin
        if (idx_reg < job.nflush)
        begin
            item_next.codepoint  = {{(CpW-ByteW){1'b0}}, flush_byte};
            item_next.bytes_used = 3'd1;
        end
        else
        begin
            item_next.codepoint  = job.final_cp;
            item_next.bytes_used = job.final_used;
        end
        item_next.run_end  = last_res;
        item_next.text_end = last_res && job.last;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = last_res ? '0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (take)
                valid_reg <= 1'b1;
            else if (cp_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign cp_valid = valid_reg;
    assign cp_item  = item_reg;

endmodule

FILE: rtl/core/utf8_codepoint_decoder_unit.sv
// utf8_codepoint_decoder_unit: top level of the utf-8 codepoint decoder
// depends on ucd_pkg, ucd_front, ucd_queue and ucd_back
//
// usage
//   byte channel (byte_valid/byte_ready/byte_item): one text byte per item,
//   with end_of_text set on the last byte of a text
//   codepoint channel (cp_valid/cp_ready/cp_item): decoded codepoints, or raw
//   byte values when a sequence breaks; run_end marks the last item caused by
//   a byte, text_end the final item of a text
//   a byte item gives zero to four codepoint items
// timing
//   first codepoint of a byte goes through the job queue, then the output register
//   one byte taken per cycle while the four-job queue has room
//   one codepoint item leaves per cycle while cp_ready is high; a byte that breaks
//   a sequence gives a burst of up to four, which the queue absorbs
// reset
//   asynchronous, clears the open sequence, the queue and the output valid flag
// stall
//   a stalled receiver holds the output register; bytes keep coming in until
//   the queue fills, then byte_ready drops
module utf8_codepoint_decoder_unit
    import ucd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  ucd_in_t  byte_item,
    output logic     cp_valid,
    input  logic     cp_ready,
    output ucd_out_t cp_item
);

    logic      accept;
    logic      job_valid;
    ucd_job_t  front_job;
    ucd_job_t  head_job;
    logic      q_full;
    logic      q_empty;
    logic      pop;
    ucd_qctl_t qctl;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;

    ucd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (byte_item),
        .job_valid (job_valid),
        .job       (front_job)
    );

    always_comb
    begin
        qctl.push  = job_valid;
        qctl.pop   = pop;
    end

    ucd_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_job (front_job),
        .rd_job (head_job),
        .ctl_in (qctl),
        .full   (q_full),
        .empty  (q_empty)
    );

    ucd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (head_job),
        .empty    (q_empty),
        .pop      (pop),
        .cp_valid (cp_valid),
        .cp_ready (cp_ready),
        .cp_item  (cp_item)
    );

`ifndef SYNTHESIS
    // a byte ending a text always leaves a job behind
    a_eot_queued: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_item.end_of_text |=> !q_empty)
        else $error("end of text byte left no job");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !qctl.push)
        else $error("job queue overflow");

    a_text_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && cp_item.text_end |-> cp_item.run_end)
        else $error("text_end without run_end");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");
`endif

endmodule
